### sv/stdeg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stdeg_pkg;

    localparam int unsigned FRAC_BITS   = 28;
    localparam int unsigned MAG_W       = 15;
    localparam int unsigned X_W         = 30;
    localparam int unsigned TERM_W      = 32;
    localparam int unsigned SUM_W       = 34;
    localparam int unsigned N_W         = 36;
    localparam int unsigned SPLIT       = 17;
    localparam int unsigned NH_W        = N_W - SPLIT;
    localparam int unsigned DIV_W       = 9;
    localparam int unsigned RECIP_SHIFT = 35;
    localparam int unsigned RECIP_W     = 33;
    localparam int unsigned RES_W       = 16;

    // The limit of 180 degrees in input units, and pi / 23040 split into
    // an integer part and a remainder over 368640 = 45 * 2^13.
    localparam logic [16:0] ANGLE_LIMIT = 17'd23040;
    localparam logic [15:0] RAD_INT     = 16'd36602;
    localparam logic [16:0] RAD_REM     = 17'd76425;
    localparam logic [17:0] RAD_ROUND   = 18'd184320;
    localparam logic [18:0] DIV45_RECIP = 19'd372828;

    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(4096);
    localparam logic [20:0]      POS_MAX    = 21'd32767;
    localparam logic [20:0]      NEG_MAX    = 21'd32768;

    typedef struct packed {
        logic                    neg;
        logic [TERM_W-1:0]       x2;
        logic signed [SUM_W-1:0] sum;
    } carry_t;

endpackage

`default_nettype wire

### sv/sine_taylor_degrees_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Sine of an angle in degrees (signed, units of 1/128 degree, clamped to
// plus or minus 180 degrees) by a NUM_TERMS-term Taylor series, returned as
// saturated signed Q1.15. The block accepts one transaction every cycle while
// the output is not stalled. Each series term after the first has five
// register stages, which multiply by x^2 and divide exactly by the factorial
// step in two halves. A stalled output holds the whole pipeline.
module sine_taylor_degrees_core #(
    parameter int unsigned NUM_TERMS = 9
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    input  wire signed [15:0] angle_deg,
    output logic              out_valid,
    input  wire               out_ready,
    output logic signed [15:0] sine_value
);

    import stdeg_pkg::*;

    logic en;

    logic             f0_vld_reg;
    logic             f0_neg_reg;
    logic [MAG_W-1:0] f0_mag_reg;
    logic [16:0]      abs_val;
    logic [MAG_W-1:0] mag_next;

    logic        f1_vld_reg;
    logic        f1_neg_reg;
    logic [30:0] f1_amag_reg;
    logic [30:0] f1_t_reg;
    logic [31:0] t_next;

    logic        f2_vld_reg;
    logic        f2_neg_reg;
    logic [30:0] f2_amag_reg;
    logic [12:0] f2_qd_reg;
    logic [36:0] qd_prod;

    logic           f3_vld_reg;
    logic           f3_neg_reg;
    logic [X_W-1:0] f3_x_reg;
    logic [30:0]    x_sum;
    logic [59:0]    x_sq;

    logic              link_v   [NUM_TERMS];
    carry_t            link_c   [NUM_TERMS];
    logic [TERM_W-1:0] link_t   [NUM_TERMS];

    logic              link0_v_reg;
    carry_t            link0_c_reg;
    logic [TERM_W-1:0] link0_t_reg;

    logic                    out_valid_reg;
    logic signed [RES_W-1:0] out_reg;
    logic signed [RES_W-1:0] out_next;
    carry_t                  last_c;
    logic                    s_neg;
    logic [SUM_W-1:0]        s_mag;
    logic [SUM_W-1:0]        s_round;
    logic [20:0]             r_val;

    assign en       = ~out_valid_reg | out_ready;
    assign in_ready = en;

    assign abs_val  = angle_deg[15] ? 17'(17'h10000 - {1'b0, angle_deg}) : {1'b0, angle_deg};
    assign mag_next = (abs_val > ANGLE_LIMIT) ? MAG_W'(ANGLE_LIMIT) : abs_val[MAG_W-1:0];

    assign t_next  = 32'(f0_mag_reg) * 32'(RAD_REM) + 32'(RAD_ROUND);
    assign qd_prod = 37'(f1_t_reg[30:13]) * 37'(DIV45_RECIP);
    assign x_sum   = f2_amag_reg + 31'(f2_qd_reg);
    assign x_sq    = 60'(f3_x_reg) * 60'(f3_x_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_vld_reg  <= 1'b0;
            f1_vld_reg  <= 1'b0;
            f2_vld_reg  <= 1'b0;
            f3_vld_reg  <= 1'b0;
            link0_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f0_vld_reg  <= in_valid;
            f1_vld_reg  <= f0_vld_reg;
            f2_vld_reg  <= f1_vld_reg;
            f3_vld_reg  <= f2_vld_reg;
            link0_v_reg <= f3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f0_neg_reg      <= angle_deg[15];
            f0_mag_reg      <= mag_next;
            f1_neg_reg      <= f0_neg_reg;
            f1_amag_reg     <= 31'(f0_mag_reg) * 31'(RAD_INT);
            f1_t_reg        <= t_next[30:0];
            f2_neg_reg      <= f1_neg_reg;
            f2_amag_reg     <= f1_amag_reg;
            f2_qd_reg       <= qd_prod[36:24];
            f3_neg_reg      <= f2_neg_reg;
            f3_x_reg        <= x_sum[X_W-1:0];
            link0_c_reg.neg <= f3_neg_reg;
            link0_c_reg.x2  <= x_sq[59:FRAC_BITS];
            link0_c_reg.sum <= $signed(SUM_W'(f3_x_reg));
            link0_t_reg     <= TERM_W'(f3_x_reg);
        end
    end

    assign link_v[0] = link0_v_reg;
    assign link_c[0] = link0_c_reg;
    assign link_t[0] = link0_t_reg;

    for (genvar g = 0; g < NUM_TERMS - 1; g++)
    begin : g_term
        localparam int unsigned K        = g + 2;
        localparam int unsigned DIV      = (2 * K - 2) * (2 * K - 1);
        localparam logic [DIV_W-1:0] DIV_V = DIV_W'(DIV);
        localparam logic [RECIP_W-1:0] RECIP =
            RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV));
        localparam bit SUBTRACT = (K % 2) == 0;

        logic [63:0]              p1;
        logic [NH_W+RECIP_W-1:0]  p2;
        logic [27:0]              rem3;
        logic [SPLIT+DIV_W+RECIP_W-1:0] p4;
        logic [SUM_W-1:0]         q5;
        logic signed [SUM_W-1:0]  sum5;

        logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
        carry_t c1_reg, c2_reg, c3_reg, c4_reg, c5_reg;
        logic [N_W-1:0]   n1_reg;
        logic [NH_W-1:0]  nh2_reg;
        logic [SPLIT-1:0] nl2_reg;
        logic [SPLIT-1:0] qh2_reg;
        logic [SPLIT-1:0] qh3_reg;
        logic [SPLIT+DIV_W-1:0] n3_reg;
        logic [SPLIT-1:0] qh4_reg;
        logic [SPLIT-1:0] ql4_reg;
        logic [TERM_W-1:0] t5_reg;

        assign p1   = 64'(link_t[g]) * 64'(link_c[g].x2);
        assign p2   = (NH_W+RECIP_W)'(n1_reg[N_W-1:SPLIT]) * (NH_W+RECIP_W)'(RECIP);
        assign rem3 = 28'(nh2_reg) - 28'(qh2_reg) * 28'(DIV_V);
        assign p4   = (SPLIT+DIV_W+RECIP_W)'(n3_reg) * (SPLIT+DIV_W+RECIP_W)'(RECIP);
        assign q5   = {qh4_reg, ql4_reg};
        assign sum5 = SUBTRACT ? c4_reg.sum - $signed(q5) : c4_reg.sum + $signed(q5);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v1_reg <= 1'b0;
                v2_reg <= 1'b0;
                v3_reg <= 1'b0;
                v4_reg <= 1'b0;
                v5_reg <= 1'b0;
            end
            else if (en)
            begin
                v1_reg <= link_v[g];
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
                v5_reg <= v4_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                c1_reg     <= link_c[g];
                n1_reg     <= p1[FRAC_BITS+N_W-1:FRAC_BITS];
                c2_reg     <= c1_reg;
                nh2_reg    <= n1_reg[N_W-1:SPLIT];
                nl2_reg    <= n1_reg[SPLIT-1:0];
                qh2_reg    <= p2[RECIP_SHIFT+SPLIT-1:RECIP_SHIFT];
                c3_reg     <= c2_reg;
                qh3_reg    <= qh2_reg;
                n3_reg     <= {rem3[DIV_W-1:0], nl2_reg};
                c4_reg     <= c3_reg;
                qh4_reg    <= qh3_reg;
                ql4_reg    <= p4[RECIP_SHIFT+SPLIT-1:RECIP_SHIFT];
                c5_reg.neg <= c4_reg.neg;
                c5_reg.x2  <= c4_reg.x2;
                c5_reg.sum <= sum5;
                t5_reg     <= q5[TERM_W-1:0];
            end
        end

        assign link_v[g+1] = v5_reg;
        assign link_c[g+1] = c5_reg;
        assign link_t[g+1] = t5_reg;
    end

    assign last_c  = link_c[NUM_TERMS-1];
    assign s_neg   = last_c.sum[SUM_W-1];
    assign s_mag   = s_neg ? SUM_W'(-last_c.sum) : SUM_W'(last_c.sum);
    assign s_round = s_mag + ROUND_HALF;
    assign r_val   = s_round[SUM_W-1:13];

    always_comb
    begin
        if (s_neg != last_c.neg)
        begin
            out_next = (r_val > NEG_MAX) ? RES_W'(-NEG_MAX) : RES_W'(-r_val);
        end
        else
        begin
            out_next = (r_val > POS_MAX) ? RES_W'(POS_MAX) : RES_W'(r_val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= link_v[NUM_TERMS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sine_value = out_reg;

endmodule

`default_nettype wire
